/* rtl/sprite_xor_framebuffer_core_macros.svh */
// Assertion helpers shared by the frame store RTL.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef SPRITE_XOR_FRAMEBUFFER_CORE_MACROS_SVH
`define SPRITE_XOR_FRAMEBUFFER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SXFB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SXFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sxfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sxfb_pkg;

	localparam int unsigned DEF_COLS = 64;
	localparam int unsigned DEF_ROWS = 32;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2
	} req_code_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] row_bits;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [3:0] row_offset;
		logic       last_row;
	} in_item_t;

	typedef struct packed {
		logic        collision;
		logic        sprite_done;
		logic [63:0] row_pixels;
	} out_item_t;

	// Status of one draw row, from the row operator to the top level.
	typedef struct packed {
		logic in_range;
		logic collision;
	} draw_stat_t;

endpackage

`default_nettype wire

/* rtl/sxfb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sxfb_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/sxfb_draw.sv */
`timescale 1ns / 1ps
`default_nettype none

module sxfb_draw #(
	parameter int unsigned SCREEN_COLS = sxfb_pkg::DEF_COLS,
	parameter int unsigned SCREEN_ROWS = sxfb_pkg::DEF_ROWS
) (
	input  wire sxfb_pkg::in_item_t item,
	input  wire logic [7:0]        xq,
	input  wire logic [SCREEN_COLS-1:0] old_row,
	input  wire logic              acc,
	output logic [SCREEN_COLS-1:0] new_row,
	output sxfb_pkg::draw_stat_t   stat
);

	import sxfb_pkg::*;

	localparam int unsigned CW = $clog2(SCREEN_COLS);

	logic [15:0]            xsub;
	logic [CW-1:0]          xm;
	logic [CW:0]            col;
	logic [SCREEN_COLS-1:0] sprite;
	logic [8:0]             target;
	logic                   hit;

	// The quotient of x_pos by the width comes in precomputed, so only the
	// remainder is formed here.
	always_comb begin
		xsub = 16'(item.x_pos) - 16'(xq) * 16'(SCREEN_COLS);
		xm   = xsub[CW-1:0];
	end

	// Column of sprite bit 7-j is xm + j, wrapped once past the right edge.
	always_comb begin
		sprite = '0;
		col    = '0;
		for (int j = 0; j < 8; j++) begin
			col = (CW+1)'(xm) + (CW+1)'(j);
			if (col >= (CW+1)'(SCREEN_COLS)) begin
				col = col - (CW+1)'(SCREEN_COLS);
			end
			if (item.row_bits[7-j]) begin
				sprite[CW'(SCREEN_COLS - 1) - col[CW-1:0]] = 1'b1;
			end
		end
	end

	always_comb begin
		target         = 9'(item.y_pos) + 9'(item.row_offset);
		stat.in_range  = (target < 9'(SCREEN_ROWS));
		hit            = stat.in_range && ((old_row & sprite) != '0);
		stat.collision = ((item.row_offset == 4'd0) ? 1'b0 : acc) | hit;
		new_row        = old_row ^ sprite;
	end

endmodule

`default_nettype wire

/* rtl/sprite_xor_framebuffer_core.sv */
// Monochrome frame store with XOR sprite drawing.
// Request channel (req_valid, req_stall, req): draw one 8-bit sprite row at
// column x_pos and row y_pos + row_offset, clear the whole frame, or read one
// frame row. Response channel (rsp_valid, rsp_stall, rsp): exactly one result
// per request, in order. A draw returns the collision flag accumulated since
// the sprite's row zero and echoes last_row as sprite_done; a read returns the
// row with column 0 at bit 63; everything else returns zeros.
// Columns wrap around the width; a draw row below the bottom edge is dropped.
// A request is registered in stage one and its result in the register behind
// rsp_valid. One request is taken every cycle unless req_stall is high: the
// frame row is read from the RAM as the request is registered, written back
// when the item leaves stage one, and a one-entry bypass covers back-to-back
// draws to the same row. Reset darkens the frame through per-row valid bits, so
// the block takes requests in the first cycle after reset. When rsp_stall is high
// a pending result holds, and req_stall rises once stage one also holds an item.
`timescale 1ns / 1ps
`default_nettype none

module sprite_xor_framebuffer_core #(
	parameter int unsigned SCREEN_COLS = sxfb_pkg::DEF_COLS,
	parameter int unsigned SCREEN_ROWS = sxfb_pkg::DEF_ROWS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sxfb_pkg::in_item_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sxfb_pkg::out_item_t rsp
);

	import sxfb_pkg::*;

	`include "sprite_xor_framebuffer_core_macros.svh"

	localparam int unsigned AW    = $clog2(SCREEN_ROWS);
	localparam int unsigned RECIP = (65536 + SCREEN_COLS - 1) / SCREEN_COLS;
	localparam int unsigned PAD   = 64 - SCREEN_COLS;

	logic                   accept;
	logic                   out_free;
	logic                   adv_s1;
	logic [8:0]             req_row;
	logic [AW-1:0]          rd_addr;
	logic [24:0]            xprod;

	logic                   vld_s1;
	in_item_t               item_s1;
	logic [7:0]             xq_s1;
	logic [AW-1:0]          addr_s1;

	logic [SCREEN_COLS-1:0] ram_rd;
	logic [SCREEN_COLS-1:0] old_row;
	logic [SCREEN_COLS-1:0] new_row;
	draw_stat_t             stat;
	logic                   wr_en;
	logic                   is_clear;

	logic [SCREEN_ROWS-1:0] row_vld_q;
	logic                   fwd_vld_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [SCREEN_COLS-1:0] fwd_data_q;
	logic                   acc_q;

	out_item_t              rsp_d;
	out_item_t              rsp_q;
	logic                   rsp_valid_q;

	// Handshake and stage control.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign adv_s1    = vld_s1 && out_free;
	assign req_stall = vld_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	// Frame row touched by the request, and the quotient x_pos / width
	// (reciprocal multiply, exact for 8-bit x_pos).
	always_comb begin
		req_row = 9'(req.y_pos) + 9'(req.row_offset);
		if (req.req_type == REQ_READ) begin
			rd_addr = req.y_pos[AW-1:0];
		end else begin
			rd_addr = req_row[AW-1:0];
		end
		xprod = 25'(req.x_pos) * 25'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!req_stall) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			xq_s1   <= xprod[23:16];
			addr_s1 <= rd_addr;
		end
	end

	sxfb_ram #(
		.WIDTH (SCREEN_COLS),
		.DEPTH (SCREEN_ROWS)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (new_row),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// The write of the previous stage-one item lands on the same edge as this
	// item's RAM read, so the last written row is taken from the bypass.
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			old_row = fwd_data_q;
		end else if (row_vld_q[addr_s1]) begin
			old_row = ram_rd;
		end else begin
			old_row = '0;
		end
	end

	sxfb_draw #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_draw (
		.item    (item_s1),
		.xq      (xq_s1),
		.old_row (old_row),
		.acc     (acc_q),
		.new_row (new_row),
		.stat    (stat)
	);

	assign wr_en    = adv_s1 && (item_s1.req_type == REQ_DRAW) && stat.in_range;
	assign is_clear = adv_s1 && (item_s1.req_type == REQ_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			fwd_vld_q <= 1'b0;
			acc_q     <= 1'b0;
		end else begin
			if (is_clear) begin
				row_vld_q <= '0;
				fwd_vld_q <= 1'b0;
			end else if (wr_en) begin
				row_vld_q[addr_s1] <= 1'b1;
				fwd_vld_q          <= 1'b1;
			end
			if (adv_s1 && (item_s1.req_type == REQ_DRAW)) begin
				acc_q <= stat.collision;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_row;
		end
	end

	always_comb begin
		rsp_d = '0;
		case (item_s1.req_type)
			REQ_DRAW: begin
				rsp_d.collision   = stat.collision;
				rsp_d.sprite_done = item_s1.last_row;
			end
			REQ_READ: begin
				if (9'(item_s1.y_pos) < 9'(SCREEN_ROWS)) begin
					rsp_d.row_pixels = 64'(old_row) << PAD;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SXFB_ASSERT_NEXT(a_accept_fills_s1, accept, vld_s1, "accepted request missing in stage one")
	`SXFB_ASSERT_NEXT(a_clear_drops_rows, is_clear, (row_vld_q == '0) && !fwd_vld_q, "clear left a row lit")
	`SXFB_ASSERT_SAME(a_stall_means_full, req_stall, vld_s1 && rsp_valid_q, "stall without a full pipeline")
	`SXFB_ASSERT_SAME(a_read_only_pixels, rsp_valid && (rsp.row_pixels != '0), !rsp.collision && !rsp.sprite_done, "pixel data on a draw result")

endmodule

`default_nettype wire
